FILE: hw/rtl/crfe_pkg.sv
package crfe_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SCR_BITS   = 13;
  localparam int unsigned END_BITS   = SCR_BITS + 1;
  localparam int unsigned PITCH_BITS = 16;
  localparam int unsigned BPP_BITS   = 8;
  localparam int unsigned ADDR_BITS  = 32;
  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned NBYTE_BITS = 3;
  localparam int unsigned CFG_IDX_BITS = 3;

  // Default for the coordinate width parameter.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_PITCH      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BITS_PER_PIXEL = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_BASE     = 3'd4;

  // Configuration reset values.
  localparam logic [SCR_BITS-1:0]   SCREEN_WIDTH_RST   = 13'd640;
  localparam logic [SCR_BITS-1:0]   SCREEN_HEIGHT_RST  = 13'd480;
  localparam logic [PITCH_BITS-1:0] ROW_PITCH_RST      = 16'd2560;
  localparam logic [BPP_BITS-1:0]   BITS_PER_PIXEL_RST = 8'd32;
  localparam logic [ADDR_BITS-1:0]  FRAME_BASE_RST     = 32'd0;

  // Color field masks for RGB565 packing, plus byte and 24-bit RGB masks.
  localparam logic [DATA_BITS-1:0] R5_SEL     = 32'h00F8_0000;
  localparam logic [DATA_BITS-1:0] G6_SEL     = 32'h0000_FC00;
  localparam logic [DATA_BITS-1:0] B5_SEL     = 32'h0000_00F8;
  localparam logic [DATA_BITS-1:0] BYTE_MASK  = 32'h0000_00FF;
  localparam logic [DATA_BITS-1:0] RGB_MASK   = 32'h00FF_FFFF;

  typedef struct packed {
    logic                          req_type;
    logic signed [FIELD_BITS-1:0]  rect_x;
    logic signed [FIELD_BITS-1:0]  rect_y;
    logic signed [FIELD_BITS-1:0]  rect_w;
    logic signed [FIELD_BITS-1:0]  rect_h;
    logic [DATA_BITS-1:0]          fill_color;
  } in_t;

  typedef struct packed {
    logic                  write_valid;
    logic [ADDR_BITS-1:0]  write_addr;
    logic [DATA_BITS-1:0]  write_data;
    logic [NBYTE_BITS-1:0] write_bytes;
    logic                  last_write;
    logic                  rect_empty;
    logic                  busy_res;
  } out_t;

  // Bytes per pixel for a supported depth, zero otherwise.
  function automatic logic [NBYTE_BITS-1:0] bytes_per_pixel(input logic [BPP_BITS-1:0] bpp);
    logic [NBYTE_BITS-1:0] n;
    unique case (bpp)
      8'd8:    n = 3'd1;
      8'd16:   n = 3'd2;
      8'd24:   n = 3'd3;
      8'd32:   n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Pack a 0x00RRGGBB color into the framebuffer pixel format.
  function automatic logic [DATA_BITS-1:0] pack_color(input logic [DATA_BITS-1:0] c,
                                                      input logic [NBYTE_BITS-1:0] bpb);
    logic [DATA_BITS-1:0] p;
    case (bpb)
      3'd4:    p = c;
      3'd3:    p = c & RGB_MASK;
      3'd2:    p = ((c & R5_SEL) >> 8) | ((c & G6_SEL) >> 5) | ((c & B5_SEL) >> 3);
      default: p = c & BYTE_MASK;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/clipped_rect_fill_engine.sv
// Rectangle fill engine: one result per request, registered at the output.
// A result appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the output register holds a result while
// the consumer stalls and the next request is taken as soon as it is drained.
// Reset (synchronous, active low) restores the default screen setup and idles.
module clipped_rect_fill_engine #(
  parameter int unsigned COORD_BITS = crfe_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  crfe_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output crfe_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crfe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [crfe_pkg::DATA_BITS-1:0]      cfg_data
);
  import crfe_pkg::*;

  // Signed working width: holds a coordinate sum without overflow.
  localparam int unsigned CW = COORD_BITS + 2;

  // Configuration registers.
  logic [SCR_BITS-1:0]   scr_w_r, scr_h_r;
  logic [PITCH_BITS-1:0] pitch_r;
  logic [BPP_BITS-1:0]   bpp_r;
  logic [ADDR_BITS-1:0]  base_r;

  // Walk state.
  logic                  active_r, active_nxt;
  logic [SCR_BITS-1:0]   cur_col_r, cur_col_nxt;
  logic [SCR_BITS-1:0]   cur_row_r, cur_row_nxt;
  logic [SCR_BITS-1:0]   first_col_r, first_col_nxt;
  logic [END_BITS-1:0]   end_col_r, end_col_nxt;
  logic [END_BITS-1:0]   end_row_r, end_row_nxt;
  logic [ADDR_BITS-1:0]  row_addr_r, row_addr_nxt;
  logic [ADDR_BITS-1:0]  pixel_addr_r, pixel_addr_nxt;
  logic [DATA_BITS-1:0]  color_r, color_nxt;

  // Output register.
  logic                  out_valid_r;
  out_t                  out_data_r, res;

  logic in_fire, cfg_fire;

  // Start decode.
  logic signed [CW-1:0]  xs, ys, ws, hs, x0, y0, x1, y1, sw_s, sh_s;
  logic [NBYTE_BITS-1:0] bpb;
  logic                  empty;
  logic [SCR_BITS+PITCH_BITS-1:0] row_off;
  logic [SCR_BITS+NBYTE_BITS-1:0] col_off;
  logic [ADDR_BITS-1:0]  start_addr;

  // Tick step.
  logic [END_BITS-1:0]   col_inc, row_inc;
  logic                  col_done, row_done;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign bpb = bytes_per_pixel(bpp_r);

  // Clip the rectangle to the screen and to non-negative coordinates.
  always_comb begin
    xs   = CW'(signed'(in_data.rect_x[COORD_BITS-1:0]));
    ys   = CW'(signed'(in_data.rect_y[COORD_BITS-1:0]));
    ws   = CW'(signed'(in_data.rect_w[COORD_BITS-1:0]));
    hs   = CW'(signed'(in_data.rect_h[COORD_BITS-1:0]));
    sw_s = signed'(CW'(scr_w_r));
    sh_s = signed'(CW'(scr_h_r));
    x0   = xs[CW-1] ? '0 : xs;
    y0   = ys[CW-1] ? '0 : ys;
    x1   = xs + ws;
    y1   = ys + hs;
    if (x1 > sw_s) begin
      x1 = sw_s;
    end
    if (y1 > sh_s) begin
      y1 = sh_s;
    end
    empty = (x1 <= x0) || (y1 <= y0) || (base_r == '0) || (bpb == '0);
  end

  // First pixel address of a start; only meaningful when not empty.
  assign row_off    = (SCR_BITS+PITCH_BITS)'(y0[SCR_BITS-1:0]) *
                      (SCR_BITS+PITCH_BITS)'(pitch_r);
  assign col_off    = (SCR_BITS+NBYTE_BITS)'(x0[SCR_BITS-1:0]) *
                      (SCR_BITS+NBYTE_BITS)'(bpb);
  assign start_addr = base_r + ADDR_BITS'(row_off) + ADDR_BITS'(col_off);

  assign col_inc  = END_BITS'(cur_col_r) + END_BITS'(1);
  assign row_inc  = END_BITS'(cur_row_r) + END_BITS'(1);
  assign col_done = col_inc >= end_col_r;
  assign row_done = row_inc >= end_row_r;

  // Next walk state and the result of the accepted transaction.
  always_comb begin
    active_nxt     = active_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    first_col_nxt  = first_col_r;
    end_col_nxt    = end_col_r;
    end_row_nxt    = end_row_r;
    row_addr_nxt   = row_addr_r;
    pixel_addr_nxt = pixel_addr_r;
    color_nxt      = color_r;
    res            = '0;

    if (in_data.req_type == REQ_START) begin
      if (empty) begin
        active_nxt = 1'b0;
      end else begin
        active_nxt     = 1'b1;
        cur_col_nxt    = x0[SCR_BITS-1:0];
        first_col_nxt  = x0[SCR_BITS-1:0];
        cur_row_nxt    = y0[SCR_BITS-1:0];
        end_col_nxt    = x1[END_BITS-1:0];
        end_row_nxt    = y1[END_BITS-1:0];
        color_nxt      = pack_color(in_data.fill_color, bpb);
        row_addr_nxt   = start_addr;
        pixel_addr_nxt = start_addr;
      end
      res.rect_empty = empty;
    end else if (active_r) begin
      res.write_valid = 1'b1;
      res.write_addr  = pixel_addr_r;
      res.write_data  = color_r;
      res.write_bytes = bpb;
      cur_col_nxt     = col_inc[SCR_BITS-1:0];
      if (col_done) begin
        cur_row_nxt = row_inc[SCR_BITS-1:0];
        if (row_done) begin
          res.last_write = 1'b1;
          active_nxt     = 1'b0;
        end else begin
          cur_col_nxt    = first_col_r;
          row_addr_nxt   = row_addr_r + ADDR_BITS'(pitch_r);
          pixel_addr_nxt = row_addr_nxt;
        end
      end else begin
        pixel_addr_nxt = pixel_addr_r + ADDR_BITS'(bpb);
      end
    end
    res.busy_res = active_nxt;
  end

  // Configuration registers; a write to any of the five cancels a rectangle in progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_WIDTH_RST;
      scr_h_r <= SCREEN_HEIGHT_RST;
      pitch_r <= ROW_PITCH_RST;
      bpp_r   <= BITS_PER_PIXEL_RST;
      base_r  <= FRAME_BASE_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:   scr_w_r <= cfg_data[SCR_BITS-1:0];
        CFG_SCREEN_HEIGHT:  scr_h_r <= cfg_data[SCR_BITS-1:0];
        CFG_ROW_PITCH:      pitch_r <= cfg_data[PITCH_BITS-1:0];
        CFG_BITS_PER_PIXEL: bpp_r   <= cfg_data[BPP_BITS-1:0];
        CFG_FRAME_BASE:     base_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Walk state control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cfg_fire && (cfg_index <= CFG_FRAME_BASE)) begin
      active_r <= 1'b0;
    end else if (in_fire) begin
      active_r <= active_nxt;
    end
  end

  // Walk state payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      first_col_r  <= first_col_nxt;
      end_col_r    <= end_col_nxt;
      end_row_r    <= end_row_nxt;
      row_addr_r   <= row_addr_nxt;
      pixel_addr_r <= pixel_addr_nxt;
      color_r      <= color_nxt;
    end
  end

  // Output register: holds a result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

endmodule
